// ===== hw/rtl/circular_deque_core_defines.svh =====
// Assertion macros used by the port checker (cdq_checker) of the circular deque.
`ifndef CIRCULAR_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular deque check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular deque check failed");

`endif

// ===== hw/rtl/cdq_pkg.sv =====
// Shared types and constants of the circular deque.
package cdq_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_REAR  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } t_cmd;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

// ===== hw/rtl/cdq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module cdq_ram #(
    parameter int WIDTH = cdq_pkg::WORD_W,
    parameter int DEPTH = cdq_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/circular_deque_core.sv =====
// Top level of the circular deque: command decode, pointers and result buffering.
//
// Usage: each word on the slave stream is one command. tuser carries the
// command code (push rear, push front, pop front, pop rear, peek front, peek
// rear) and tdata the word to insert for a push. Every command returns exactly
// one word on the master stream: tdata holds the word removed or peeked (zero
// for pushes, errors and unknown codes), tuser holds the status and the empty
// and full flags as they stand after the command.
// A push, an error or an unknown code passes its result straight to the output
// register (to the skid register while the output waits); a pop or peek passes
// through the registered read port of the slot memory first. Pushes are taken
// one per cycle while s_axis_tready stays high; a pop or peek holds the decoder
// until its data returns, so no new command is taken meanwhile.
// The ring holds at most SLOTS-1 words. A push into a full ring reports
// overflow and a pop or peek of an empty ring reports underflow; neither
// changes any state.
// Reset clears both pointers, so the deque starts empty; the slot memory is
// not cleared, since no slot is read before a push has written it.
// Results pass through an output register backed by one skid register, so a
// new command is still taken while one finished result waits for the
// receiver. Once both are full, s_axis_tready drops until the receiver
// takes a word; nothing is lost or repeated while it stalls.
module circular_deque_core #(
    parameter int SLOTS = cdq_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: push_value[31:0]
    input  logic [cdq_pkg::WORD_W-1:0]  s_axis_tdata,
    // tuser: command[2:0]
    input  logic [cdq_pkg::CMD_W-1:0]   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata: read_value[31:0]
    output logic [cdq_pkg::WORD_W-1:0]  m_axis_tdata,
    // tuser: status[1:0], is_empty[2], is_full[3]
    output logic [cdq_pkg::STAT_W+1:0]  m_axis_tuser
);

    localparam int PTR_W = $clog2(SLOTS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOTS - 1);
    localparam int RES_W = cdq_pkg::WORD_W + cdq_pkg::STAT_W + 2;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    logic [PTR_W-1:0] r_front;
    logic [PTR_W-1:0] r_rear;

    // Flags and status of a read in flight, applied when the data returns.
    logic [cdq_pkg::STAT_W+1:0] r_rd_meta;

    logic             r_out_valid;
    logic [RES_W-1:0] r_out;
    logic             r_res_valid;
    logic [RES_W-1:0] r_res;

    logic [PTR_W-1:0] front_next, front_prev, rear_next, rear_prev;
    logic [PTR_W-1:0] n_front, n_rear;
    logic             cur_empty, cur_full, new_empty, new_full;
    logic [cdq_pkg::STAT_W-1:0] status;
    logic             do_write, do_read;
    logic [PTR_W-1:0] waddr, raddr;
    logic             accept, load, out_free;
    logic [RES_W-1:0] result;
    logic [cdq_pkg::WORD_W-1:0] rdata;

    assign front_next = (r_front == PTR_LAST) ? '0 : r_front + PTR_W'(1);
    assign front_prev = (r_front == '0) ? PTR_LAST : r_front - PTR_W'(1);
    assign rear_next  = (r_rear == PTR_LAST) ? '0 : r_rear + PTR_W'(1);
    assign rear_prev  = (r_rear == '0) ? PTR_LAST : r_rear - PTR_W'(1);

    assign cur_empty = (r_front == r_rear);
    assign cur_full  = (rear_next == r_front);

    // Decode one command against the current pointers.
    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        status   = cdq_pkg::ST_OK;
        do_write = 1'b0;
        do_read  = 1'b0;
        waddr    = rear_next;
        raddr    = r_rear;
        case (s_axis_tuser)
            cdq_pkg::CMD_PUSH_REAR: begin
                if (cur_full) begin
                    status = cdq_pkg::ST_OVERFLOW;
                end else begin
                    n_rear   = rear_next;
                    waddr    = rear_next;
                    do_write = 1'b1;
                end
            end
            cdq_pkg::CMD_PUSH_FRONT: begin
                if (cur_full) begin
                    status = cdq_pkg::ST_OVERFLOW;
                end else begin
                    n_front  = front_prev;
                    waddr    = r_front;
                    do_write = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_FRONT: begin
                if (cur_empty) begin
                    status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    n_front = front_next;
                    raddr   = front_next;
                    do_read = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_REAR: begin
                if (cur_empty) begin
                    status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    n_rear  = rear_prev;
                    raddr   = r_rear;
                    do_read = 1'b1;
                end
            end
            cdq_pkg::CMD_PEEK_FRONT: begin
                if (cur_empty) begin
                    status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    raddr   = front_next;
                    do_read = 1'b1;
                end
            end
            cdq_pkg::CMD_PEEK_REAR: begin
                if (cur_empty) begin
                    status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    raddr   = r_rear;
                    do_read = 1'b1;
                end
            end
            default: begin
                // Unknown codes leave everything as it is.
            end
        endcase
    end

    // Flags as they stand after the command; the steps above stay in the ring.
    assign new_empty = (n_front == n_rear);
    assign new_full  = (((n_rear == PTR_LAST) ? '0 : n_rear + PTR_W'(1)) == n_front);

    // One command in the decoder at a time, and the skid register must be free.
    assign s_axis_tready = (r_state == S_IDLE) && !r_res_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cdq_ram #(
        .WIDTH (cdq_pkg::WORD_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (accept && do_write),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (accept && do_read),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // A result is produced at once for a command without a read, or when the
    // read data returns.
    assign load   = (r_state == S_READ) || (accept && !do_read);
    assign result = (r_state == S_READ)
                  ? {r_rd_meta, rdata}
                  : {new_full, new_empty, status, cdq_pkg::WORD_W'(0)};
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_rear      <= '0;
            r_out_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_front   <= n_front;
                        r_rear    <= n_rear;
                        r_rd_meta <= {new_full, new_empty, status};
                        if (do_read) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Output register with a skid register behind it; the skid
            // entry always drains first to keep results in order.
            if (out_free) begin
                r_out_valid <= r_res_valid || load;
                if (r_res_valid) begin
                    r_out <= r_res;
                    if (load) begin
                        r_res <= result;
                    end else begin
                        r_res_valid <= 1'b0;
                    end
                end else if (load) begin
                    r_out <= result;
                end
            end else if (load) begin
                r_res       <= result;
                r_res_valid <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out[cdq_pkg::WORD_W-1:0];
    assign m_axis_tuser  = r_out[RES_W-1:cdq_pkg::WORD_W];

endmodule

// ===== hw/rtl/cdq_checker.sv =====
// Port-level checks of the circular deque, bound to its top level.
`include "circular_deque_core_defines.svh"

module cdq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [cdq_pkg::WORD_W-1:0]  m_axis_tdata,
    input logic [cdq_pkg::STAT_W+1:0]  m_axis_tuser
);

    logic [cdq_pkg::STAT_W-1:0] status;
    logic                       is_empty, is_full;

    assign status   = m_axis_tuser[cdq_pkg::STAT_W-1:0];
    assign is_empty = m_axis_tuser[cdq_pkg::STAT_W];
    assign is_full  = m_axis_tuser[cdq_pkg::STAT_W+1];

    // A stalled result word holds until the receiver takes it.
    `CDQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A failed command returns no data.
    `CDQ_ASSERT_NOW(a_err_zero, i_clk, i_rst_n,
        m_axis_tvalid && (status != cdq_pkg::ST_OK), m_axis_tdata == '0)

    // Overflow only ever happens on a full ring, which it leaves full.
    `CDQ_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n,
        m_axis_tvalid && (status == cdq_pkg::ST_OVERFLOW), is_full && !is_empty)

    // Underflow only ever happens on an empty ring, which it leaves empty.
    `CDQ_ASSERT_NOW(a_udf_empty, i_clk, i_rst_n,
        m_axis_tvalid && (status == cdq_pkg::ST_UNDERFLOW), is_empty && !is_full)

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
